// ===== src/lfo_flanger_effect_assert.svh =====
// ---------------------------------------------------------------------------
// lfo_flanger_effect_assert.svh
// Assertion macros shared by the flanger modules. Both expect clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef LFO_FLANGER_EFFECT_ASSERT_SVH
`define LFO_FLANGER_EFFECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfe: assertion failed");

// Next-cycle implication, disabled during reset.
`define LFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfe: assertion failed");

`endif

// ===== src/lfe_pkg.sv =====
// ---------------------------------------------------------------------------
// lfe_pkg
// Constants, types and the sine quarter-wave table of the flanger.
// ---------------------------------------------------------------------------
`default_nettype none

package lfe_pkg;

  // Sizes
  localparam int BUFFER_DEPTH     = 1024;
  localparam int SINE_TABLE_DEPTH = 1024;   // power of two
  localparam int BUF_AW     = $clog2(BUFFER_DEPTH);
  localparam int PTR_EXT_W  = BUF_AW + 1;
  localparam int CNT_W      = $clog2(BUFFER_DEPTH + 1);
  localparam int SINE_AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QTR   = SINE_TABLE_DEPTH / 4;
  localparam int QTR_AW     = SINE_AW - 2;

  // Field and register widths
  localparam int SAMPLE_W     = 16;
  localparam int PHASE_W      = 32;
  localparam int PHASE_STEP_W = 19;
  localparam int GAIN_W       = 15;
  localparam int DELAY_CFG_W  = 18;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 19;

  // Reset values of the configuration registers
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST    = PHASE_STEP_W'(48695);
  localparam logic [GAIN_W-1:0]       DEPTH_GAIN_RST    = GAIN_W'(22938);
  localparam logic [GAIN_W-1:0]       FEEDBACK_GAIN_RST = GAIN_W'(9830);
  localparam logic [GAIN_W-1:0]       WET_LEVEL_RST     = GAIN_W'(13107);
  localparam logic [DELAY_CFG_W-1:0]  BASE_DELAY_RST    = DELAY_CFG_W'(11290);
  localparam logic [DELAY_CFG_W-1:0]  DELAY_SWING_RST   = DELAY_CFG_W'(101606);

  localparam logic [GAIN_W-1:0] FEEDBACK_MAX = GAIN_W'(31130);

  // Delay in samples with 8 fraction bits
  localparam int DELAY_W   = 21;
  localparam int DELAY_MAX = (BUFFER_DEPTH - 1) * 256;

  // Shared multiplier
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 33;
  localparam int SAT_W   = 34;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SINE_DEPTH,
    MUL_U_SWING,
    MUL_TAP_NEAR,
    MUL_TAP_FAR,
    MUL_FEEDBACK,
    MUL_DRY,
    MUL_WET
  } mul_sel_t;

  typedef struct packed {
    logic     accept;      // latch sample, look up sine, step phase
    mul_sel_t mul_sel;
    logic     load_delay;  // whole delay and fraction from swing product
    logic     rd_near;
    logic     rd_far;
    logic     cap_near;
    logic     cap_far;
    logic     save_acc;
    logic     load_wet;
    logic     wr_en;       // ring write, pointer advance
    logic     load_out;
  } lfe_cmd_t;

  typedef logic signed [SAMPLE_W-1:0] quarter_rom_t [SINE_QTR];

  // Sine of a quarter-wave position r (Q30, 0 .. 2^30), Taylor series in Q30
  function automatic logic signed [SAMPLE_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    longint      q;
    t    = (r * HALF_PI_Q30) >> 30;
    t2   = (t * t) >> 30;
    term = t;
    sum  = longint'(t);
    term = ((term * t2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    q = (sum * 32767 + (longint'(1) << 29)) >>> 30;
    if (q > 32767) q = 32767;
    return SAMPLE_W'(q);
  endfunction

  function automatic quarter_rom_t build_quarter();
    quarter_rom_t rom;
    for (int j = 0; j < SINE_QTR; j++) begin
      rom[j] = quarter_sine(64'(j) << (PHASE_W - SINE_AW));
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter();
  localparam logic signed [SAMPLE_W-1:0] SINE_PEAK = quarter_sine(64'h4000_0000);

  // Full-wave table entry from the quarter-wave table
  function automatic logic signed [SAMPLE_W-1:0] sine_lookup(input logic [SINE_AW-1:0] idx);
    logic [QTR_AW-1:0]          j;
    logic                       peak;
    logic signed [SAMPLE_W-1:0] q;
    j    = idx[QTR_AW-1:0];
    peak = 1'b0;
    if (idx[SINE_AW-2]) begin
      // falling quarter; its first entry is the crest
      if (j == '0) peak = 1'b1;
      else j = QTR_AW'(SINE_QTR - int'(j));
    end
    q = peak ? SINE_PEAK : QUARTER_ROM[j];
    if (idx[SINE_AW-1]) q = -q;
    return q;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(32767)) return 16'sh7fff;
    if (v < -SAT_W'(32768)) return -16'sh8000;
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/lfe_ram.sv =====
// ---------------------------------------------------------------------------
// lfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/lfe_ctrl.sv =====
// ---------------------------------------------------------------------------
// lfe_ctrl
// Sequencer of the flanger: steps one sample through the shared multiplier
// and the ring RAM, and owns the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lfo_flanger_effect_assert.svh"

module lfe_ctrl
  import lfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lfe_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LFO,
    S_MUL_SWING,
    S_DELAY,
    S_RD1,
    S_RD2,
    S_MUL_T1,
    S_MUL_T2,
    S_WET,
    S_MUL_FB,
    S_MUL_DRY,
    S_MUL_WET,
    S_MIX
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_MUL_LFO;
      end
      S_MUL_LFO: begin
        cmd.mul_sel = MUL_SINE_DEPTH;
        state_nxt   = S_MUL_SWING;
      end
      S_MUL_SWING: begin
        cmd.mul_sel = MUL_U_SWING;
        state_nxt   = S_DELAY;
      end
      S_DELAY: begin
        cmd.load_delay = 1'b1;
        state_nxt      = S_RD1;
      end
      S_RD1: begin
        cmd.rd_near = 1'b1;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.cap_near = 1'b1;
        cmd.rd_far   = 1'b1;
        state_nxt    = S_MUL_T1;
      end
      S_MUL_T1: begin
        cmd.cap_far = 1'b1;
        cmd.mul_sel = MUL_TAP_NEAR;
        state_nxt   = S_MUL_T2;
      end
      S_MUL_T2: begin
        cmd.save_acc = 1'b1;
        cmd.mul_sel  = MUL_TAP_FAR;
        state_nxt    = S_WET;
      end
      S_WET: begin
        cmd.load_wet = 1'b1;
        state_nxt    = S_MUL_FB;
      end
      S_MUL_FB: begin
        cmd.mul_sel = MUL_FEEDBACK;
        state_nxt   = S_MUL_DRY;
      end
      S_MUL_DRY: begin
        cmd.wr_en   = 1'b1;
        cmd.mul_sel = MUL_DRY;
        state_nxt   = S_MUL_WET;
      end
      S_MUL_WET: begin
        cmd.save_acc = 1'b1;
        cmd.mul_sel  = MUL_WET;
        state_nxt    = S_MIX;
      end
      S_MIX: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LFE_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_MUL_LFO)
  `LFE_ASSERT_NEXT(a_mix_holds, state_r == S_MIX && out_valid_r && !out_ready, state_r == S_MIX)
  `LFE_ASSERT_NEXT(a_load_out, cmd.load_out, out_valid_r && state_r == S_IDLE)

endmodule

`default_nettype wire

// ===== src/lfe_datapath.sv =====
// ---------------------------------------------------------------------------
// lfe_datapath
// Flanger datapath: configuration registers, LFO phase, shared multiplier,
// ring buffer with fill count, interpolation, feedback and mix.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lfo_flanger_effect_assert.svh"

module lfe_datapath
  import lfe_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire lfe_cmd_t                   cmd,
  output logic signed [SAMPLE_W-1:0]      out_sample_out
);

  localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH_GAIN    = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_GAIN = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_WET_LEVEL     = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_DELAY    = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_SWING   = CFG_ADDR_W'(5);

  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic [GAIN_W-1:0]       depth_gain_r;
  logic [GAIN_W-1:0]       feedback_gain_r;
  logic [GAIN_W-1:0]       wet_level_r;
  logic [DELAY_CFG_W-1:0]  base_delay_r;
  logic [DELAY_CFG_W-1:0]  delay_swing_r;

  logic [PHASE_W-1:0]  phase_r;
  logic [BUF_AW-1:0]   wp_r;
  logic [CNT_W-1:0]    count_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] sine_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [BUF_AW-1:0]          n_r;
  logic [7:0]                 f_r;
  logic signed [SAMPLE_W-1:0] tap_near_r;
  logic signed [SAMPLE_W-1:0] tap_far_r;
  logic signed [SAMPLE_W-1:0] wet_r;
  logic signed [SAMPLE_W-1:0] out_r;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= PHASE_STEP_RST;
      depth_gain_r    <= DEPTH_GAIN_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      wet_level_r     <= WET_LEVEL_RST;
      base_delay_r    <= BASE_DELAY_RST;
      delay_swing_r   <= DELAY_SWING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PHASE_STEP:    phase_step_r    <= cfg_wdata[PHASE_STEP_W-1:0];
        CFG_DEPTH_GAIN:    depth_gain_r    <= cfg_wdata[GAIN_W-1:0];
        CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_WET_LEVEL:     wet_level_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_BASE_DELAY:    base_delay_r    <= cfg_wdata[DELAY_CFG_W-1:0];
        CFG_DELAY_SWING:   delay_swing_r   <= cfg_wdata[DELAY_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- derived values ----
  logic [GAIN_W-1:0]          fb_gain;
  logic [SAMPLE_W-1:0]        dry_gain;
  logic signed [16:0]         lfo;
  logic signed [MUL_A_W-1:0]  u_val;
  logic [19:0]                swing_term;
  logic [DELAY_W-1:0]         delay_raw;
  logic [DELAY_W-1:0]         delay_cl;
  logic [BUF_AW-1:0]          n_far;
  logic [BUF_AW-1:0]          tap_n;
  logic [BUF_AW-1:0]          rd_addr;
  logic                       near_ok;
  logic                       far_ok;
  logic                       full;

  assign fb_gain  = (feedback_gain_r > FEEDBACK_MAX) ? FEEDBACK_MAX : feedback_gain_r;
  assign dry_gain = SAMPLE_W'(32768) - SAMPLE_W'(wet_level_r);

  assign lfo   = $signed(prod_r[31:15]);
  assign u_val = MUL_A_W'(lfo) + MUL_A_W'(32768);

  assign swing_term = prod_r[35:16];
  assign delay_raw  = DELAY_W'(base_delay_r) + DELAY_W'(swing_term);
  assign delay_cl   = (delay_raw > DELAY_W'(DELAY_MAX)) ? DELAY_W'(DELAY_MAX) : delay_raw;

  assign n_far = (n_r == BUF_AW'(BUFFER_DEPTH - 1)) ? n_r : n_r + 1'b1;
  assign tap_n = cmd.rd_far ? n_far : n_r;

  always_comb begin
    if (wp_r >= tap_n) rd_addr = wp_r - tap_n;
    else rd_addr = BUF_AW'(PTR_EXT_W'(wp_r) + PTR_EXT_W'(BUFFER_DEPTH) - PTR_EXT_W'(tap_n));
  end

  // slots not yet written since reset read as zero
  assign full    = (count_r == CNT_W'(BUFFER_DEPTH));
  assign near_ok = full || (n_r != '0 && CNT_W'(n_r) <= count_r);
  assign far_ok  = full || (n_far != '0 && CNT_W'(n_far) <= count_r);

  // ---- shared multiplier ----
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_SINE_DEPTH: begin
        mul_a = MUL_A_W'(sine_r);
        mul_b = $signed(MUL_B_W'(depth_gain_r));
      end
      MUL_U_SWING: begin
        mul_a = u_val;
        mul_b = $signed(MUL_B_W'(delay_swing_r));
      end
      MUL_TAP_NEAR: begin
        mul_a = MUL_A_W'(tap_near_r);
        mul_b = $signed(MUL_B_W'(9'd256 - 9'(f_r)));
      end
      MUL_TAP_FAR: begin
        mul_a = MUL_A_W'(tap_far_r);
        mul_b = $signed(MUL_B_W'(f_r));
      end
      MUL_FEEDBACK: begin
        mul_a = MUL_A_W'(wet_r);
        mul_b = $signed(MUL_B_W'(fb_gain));
      end
      MUL_DRY: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = $signed(MUL_B_W'(dry_gain));
      end
      MUL_WET: begin
        mul_a = MUL_A_W'(wet_r);
        mul_b = $signed(MUL_B_W'(wet_level_r));
      end
      default: ;
    endcase
  end

  // ---- rounding and saturation ----
  logic signed [SAT_W-1:0]    pair_sum;
  logic signed [SAT_W-1:0]    wet_sum;
  logic signed [SAT_W-1:0]    mix_sum;
  logic signed [31:0]         fb_round;
  logic signed [31:0]         fb_term;
  logic signed [SAT_W-1:0]    ring_sum;
  logic signed [SAMPLE_W-1:0] ring_data;

  assign pair_sum  = SAT_W'(acc_r) + SAT_W'($signed(prod_r[ACC_W-1:0]));
  assign wet_sum   = pair_sum + SAT_W'(128);
  assign mix_sum   = (pair_sum + SAT_W'(16384)) >>> 15;
  assign fb_round  = $signed(prod_r[31:0]) + 32'sd16384;
  assign fb_term   = fb_round >>> 15;
  assign ring_sum  = SAT_W'(x_r) + SAT_W'(fb_term);
  assign ring_data = sat16(ring_sum);

  // ---- ring buffer ----
  logic [SAMPLE_W-1:0] ram_rdata;

  lfe_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wp_r),
    .wr_data (ring_data),
    .rd_en   (cmd.rd_near | cmd.rd_far),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // ---- state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      if (cmd.accept) phase_r <= phase_r + PHASE_W'(phase_step_r);
      if (cmd.wr_en) begin
        wp_r <= (wp_r == BUF_AW'(BUFFER_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (!full) count_r <= count_r + 1'b1;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= in_sample_in;
      sine_r <= sine_lookup(phase_r[PHASE_W-1 -: SINE_AW]);
    end
    if (cmd.mul_sel != MUL_NONE) prod_r <= mul_a * mul_b;
    if (cmd.load_delay) begin
      n_r <= delay_cl[BUF_AW+7:8];
      f_r <= delay_cl[7:0];
    end
    if (cmd.cap_near) tap_near_r <= near_ok ? $signed(ram_rdata) : '0;
    if (cmd.cap_far) tap_far_r <= far_ok ? $signed(ram_rdata) : '0;
    if (cmd.save_acc) acc_r <= prod_r[ACC_W-1:0];
    if (cmd.load_wet) wet_r <= wet_sum[23:8];
    if (cmd.load_out) out_r <= sat16(mix_sum);
  end

  assign out_sample_out = out_r;

  `LFE_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(BUFFER_DEPTH))
  `LFE_ASSERT_NOW(a_wp_range, 1'b1, wp_r <= BUF_AW'(BUFFER_DEPTH - 1))
  `LFE_ASSERT_NEXT(a_wr_advance, cmd.wr_en, wp_r != $past(wp_r) && count_r != '0)

endmodule

`default_nettype wire

// ===== src/lfo_flanger_effect.sv =====
// ---------------------------------------------------------------------------
// lfo_flanger_effect
// Flanger with feedback: sine LFO sweeps a fractional delay into a ring buffer.
//
// Input channel (in_valid/in_ready/in_sample_in) takes one signed Q1.15 sample
// per transfer; the result channel (out_valid/out_ready/out_sample_out) returns
// one mixed sample per input, in order. Configuration registers are written
// through cfg_we/cfg_addr/cfg_wdata; the user must write them only while no
// sample is in flight; the block itself does not enforce it. The controller walks
// each sample through seven products on the one shared multiplier and two reads
// of the single-read-port ring RAM, and takes no new sample until its result is loaded.
// Reset restores register defaults and clears LFO phase, write pointer and
// the ring fill count; slots never written read as zero, so no clearing pass
// is run and samples are accepted right after reset.
// A stalled receiver leaves the result in the output register; the next
// sample is still accepted and processed, and its result waits in the last
// step until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module lfo_flanger_effect
  import lfe_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_sample_out,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata
);

  lfe_cmd_t cmd;

  lfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lfe_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .out_sample_out (out_sample_out)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Flanger testbench: directed samples at the field and delay extremes, then
// random samples under a series of register settings, with random stalls on
// both channels. Every output sample is checked against a cycle-free
// predictor that keeps its own ring buffer, LFO phase and register copies.
// ---------------------------------------------------------------------------
module tb_top;
  import lfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 20;     // extra wait once every expected sample has come out
  localparam int unsigned IDLE_PCT    = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_GAIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_LEVEL     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_DELAY    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DELAY_SWING   = 3'd5;

  localparam int unsigned STEP_LO  = 9739;
  localparam int unsigned STEP_HI  = 486958;
  localparam int unsigned GAIN_HI  = 32767;
  localparam int unsigned DELAY_HI = 261888;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  lfo_flanger_effect i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic signed [SAMPLE_W-1:0] sine_tab [SINE_TABLE_DEPTH];
  logic signed [SAMPLE_W-1:0] ring_mem [BUFFER_DEPTH];
  logic [BUF_AW-1:0]          wr_ptr;
  logic [PHASE_W-1:0]         lfo_acc;
  logic [PHASE_STEP_W-1:0]    step_r;
  logic [GAIN_W-1:0]          depth_r;
  logic [GAIN_W-1:0]          fb_r;
  logic [GAIN_W-1:0]          wet_lvl_r;
  logic [DELAY_CFG_W-1:0]     base_r;
  logic [DELAY_CFG_W-1:0]     swing_r;

  logic signed [SAMPLE_W-1:0] mix_queue [$];

  int unsigned err_count     = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count   = 0;
  bit          idle_on       = 1'b0;

  // Sine of a 32-bit phase, Taylor series on the quarter wave in Q30
  function automatic logic signed [SAMPLE_W-1:0] lfo_sine_at(input logic [PHASE_W-1:0] ph);
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    longint      q;
    r = {34'd0, ph[29:0]};
    if (ph[30]) r = 64'h4000_0000 - r;
    t    = (r * HALF_PI_Q30) >> 30;
    t2   = (t * t) >> 30;
    term = t;
    sum  = longint'(t);
    for (int k = 1; k <= 4; k++) begin
      term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum * 32767 + (longint'(1) << 29)) >>> 30;
    if (q > 32767) q = 32767;
    if (ph[31]) q = -q;
    return SAMPLE_W'(q);
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint ring_tap(input longint n);
    longint pos;
    if (n > BUFFER_DEPTH - 1) n = BUFFER_DEPTH - 1;
    pos = (longint'(wr_ptr) + BUFFER_DEPTH - n) % BUFFER_DEPTH;
    return longint'(ring_mem[int'(pos)]);
  endfunction

  // One sample through the flanger; updates ring, pointer and phase
  function automatic logic signed [SAMPLE_W-1:0] flange_predict(
      input logic signed [SAMPLE_W-1:0] x_in);
    longint x;
    longint s;
    longint lfo;
    longint d;
    longint n;
    longint f;
    longint wet;
    longint fb;
    longint wl;
    longint mix;
    x = longint'(x_in);
    s = longint'(sine_tab[lfo_acc[PHASE_W-1 -: SINE_AW]]);
    lfo_acc = lfo_acc + PHASE_W'(step_r);
    lfo = (s * longint'(depth_r)) >>> 15;
    d = longint'(base_r) + (((lfo + 32768) * longint'(swing_r)) >>> 16);
    if (d > DELAY_MAX) d = DELAY_MAX;
    n = d >>> 8;
    f = d & 255;
    wet = (ring_tap(n) * (256 - f) + ring_tap(n + 1) * f + 128) >>> 8;
    fb = (fb_r > FEEDBACK_MAX) ? longint'(FEEDBACK_MAX) : longint'(fb_r);
    ring_mem[wr_ptr] = SAMPLE_W'(clip16(x + ((wet * fb + 16384) >>> 15)));
    wr_ptr = wr_ptr + 1'b1;
    wl = longint'(wet_lvl_r);
    mix = x * (32768 - wl) + wet * wl;
    return SAMPLE_W'(clip16((mix + 16384) >>> 15));
  endfunction

  // Write all six registers, one per cycle; the block must be idle
  task automatic load_settings(input int unsigned step, input int unsigned depth,
                               input int unsigned fb, input int unsigned wl,
                               input int unsigned base, input int unsigned swing);
    int unsigned vals [6];
    vals = '{step, depth, fb, wl, base, swing};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      case (CFG_ADDR_W'(i))
        REG_PHASE_STEP:    step_r    = PHASE_STEP_W'(vals[i]);
        REG_DEPTH_GAIN:    depth_r   = GAIN_W'(vals[i]);
        REG_FEEDBACK_GAIN: fb_r      = GAIN_W'(vals[i]);
        REG_WET_LEVEL:     wet_lvl_r = GAIN_W'(vals[i]);
        REG_BASE_DELAY:    base_r    = DELAY_CFG_W'(vals[i]);
        REG_DELAY_SWING:   swing_r   = DELAY_CFG_W'(vals[i]);
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // Offer one sample and wait for its transfer; valid stays up afterwards
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mix_queue = {mix_queue, flange_predict(s)};
    sent_count++;
  endtask

  // Hold the sender off until every expected sample has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mix_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = 16'sh7fff;
      1: v = -16'sh8000;
      2: v = SAMPLE_W'($signed($urandom_range(511)) - 256);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_reg(input int unsigned lo, input int unsigned hi);
    int unsigned v;
    case ($urandom_range(3))
      0: v = lo;
      1: v = hi;
      default: v = $urandom_range(hi, lo);
    endcase
    return v;
  endfunction

  task automatic test_default_extremes();
    logic signed [SAMPLE_W-1:0] vals [8];
    vals = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
             16'sh5555, -16'sh5556, 16'sh7fff};
    foreach (vals[i]) push_sample(vals[i]);
    wait_drained();
  endtask

  // Whole delay zero: the near tap reads the slot about to be overwritten
  task automatic test_zero_delay();
    logic signed [SAMPLE_W-1:0] vals [5];
    vals = '{16'sh7fff, -16'sh8000, 16'sh03e8, -16'sh03e8, 16'sh7fff};
    load_settings(STEP_LO, 0, 9830, 16384, 0, 0);
    foreach (vals[i]) push_sample(vals[i]);
    wait_drained();
  endtask

  // Delay beyond the buffer is clamped; far tap clamps to the last slot
  task automatic test_long_delay();
    load_settings(STEP_HI, GAIN_HI, 16384, GAIN_HI, 262143, 262143);
    repeat (4) push_sample(pick_sample());
    wait_drained();
  endtask

  // Feedback above the 0.95 ceiling, fully wet, one-sample delay
  task automatic test_feedback_clamp();
    logic signed [SAMPLE_W-1:0] vals [6];
    vals = '{16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff};
    load_settings(STEP_LO, 0, GAIN_HI, GAIN_HI, 256, 0);
    foreach (vals[i]) push_sample(vals[i]);
    wait_drained();
  endtask

  task automatic test_random_settings();
    int unsigned base;
    int unsigned swing;
    for (int ph = 0; ph < 10; ph++) begin
      // mostly short delays so the taps land on freshly written samples
      base  = ($urandom_range(3) == 0) ? pick_reg(0, DELAY_HI) : $urandom_range(12000);
      swing = ($urandom_range(3) == 0) ? pick_reg(0, DELAY_HI) : $urandom_range(20000);
      load_settings(pick_reg(STEP_LO, STEP_HI), pick_reg(0, GAIN_HI),
                    ($urandom_range(4) == 0) ? GAIN_HI : pick_reg(0, FEEDBACK_MAX),
                    pick_reg(0, GAIN_HI), base, swing);
      idle_on = (ph != 3);
      repeat (55) push_sample(pick_sample());
      idle_on = 1'b1;
      wait_drained();
    end
  endtask

  // Output checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mix_queue.size() == 0) begin
        $display("%0t: unexpected output sample %0d", $time, out_sample_out);
        err_count++;
      end else begin
        if (out_sample_out !== mix_queue[0]) begin
          $display("%0t: sample_out mismatch: expected %0d actual %0d",
                   $time, mix_queue[0], out_sample_out);
          err_count++;
        end
        void'(mix_queue.pop_front());
        checked_count++;
      end
    end
    out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d samples still expected", $time, mix_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    foreach (sine_tab[i]) sine_tab[i] = lfo_sine_at(PHASE_W'(i) << (PHASE_W - SINE_AW));
    foreach (ring_mem[i]) ring_mem[i] = '0;
    wr_ptr    = '0;
    lfo_acc   = '0;
    step_r    = PHASE_STEP_RST;
    depth_r   = DEPTH_GAIN_RST;
    fb_r      = FEEDBACK_GAIN_RST;
    wet_lvl_r = WET_LEVEL_RST;
    base_r    = BASE_DELAY_RST;
    swing_r   = DELAY_SWING_RST;

    repeat (8) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on  = 1'b1;
    @(posedge clk);

    test_default_extremes();
    test_zero_delay();
    test_long_delay();
    test_feedback_clamp();
    test_random_settings();
    wait_drained();

    $display("Covered %0d samples over %0d register settings, %0d outputs checked,",
             sent_count, setting_count, checked_count);
    $display("including zero and clamped delays and feedback above the ceiling.");
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
